// ===== src/wsc_pkg.sv =====
// Shared types, widths and constants for the wind speed to components block.
// Holds the CORDIC arctangent table and the item structs passed between stages.
// Depends on nothing.
package wsc_pkg;

  localparam int COMP_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;

  localparam int SPD_W      = 15;
  localparam int FIELD_W    = 16;
  localparam int VW         = 35;
  localparam int RW         = 34;
  localparam int AW         = 26;
  localparam int GAIN_W     = 30;
  localparam int PROD_W     = SPD_W + GAIN_W;
  localparam int MAG_SHIFT  = 14;
  localparam int FRAC_SHIFT = 16;
  localparam int DIR_SHIFT  = 9;

  localparam logic [GAIN_W-1:0]         GAIN_INV = 30'd652032875;
  localparam logic signed [AW-1:0]      ANG_90   = 26'sd5898240;
  localparam logic signed [AW-1:0]      DIR_HALF = 26'sd256;
  localparam logic signed [FIELD_W-1:0] DIR_MAX  = 16'sd23040;
  localparam logic signed [FIELD_W-1:0] DIR_MIN  = -16'sd23040;

  localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919880, 26'sd466945, 26'sd234378, 26'sd117304,
    26'sd58666,   26'sd29335,   26'sd14668,  26'sd7334,   26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,    26'sd57,     26'sd29,
    26'sd14,      26'sd7,       26'sd4,      26'sd2,      26'sd1,      26'sd0
  };

  typedef struct packed {
    logic             present;
    logic             axis;
    logic [SPD_W-1:0] spd;
  } item_flags_t;

  typedef struct packed {
    item_flags_t             flags;
    logic [PROD_W-1:0]       prod;
    logic signed [VW-1:0]    x;
    logic signed [VW-1:0]    y;
    logic signed [AW-1:0]    acc;
  } vec_data_t;

  typedef struct packed {
    item_flags_t               flags;
    logic signed [FIELD_W-1:0] dir;
    logic signed [RW-1:0]      x;
    logic signed [RW-1:0]      y;
    logic signed [AW-1:0]      z;
  } rot_data_t;

  typedef struct packed {
    logic                      result_valid;
    logic signed [FIELD_W-1:0] direction_deg;
    logic signed [FIELD_W-1:0] derived_east;
    logic signed [FIELD_W-1:0] derived_north;
  } res_t;

endpackage

// ===== src/wsc_vec_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC that finds the direction.
// Depends on wsc_pkg for the item struct and the arctangent table.
module wsc_vec_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  wsc_pkg::vec_data_t in_d,
  output logic               out_v,
  output wsc_pkg::vec_data_t out_d
);
  import wsc_pkg::*;

  logic signed [VW-1:0] dx;
  logic signed [VW-1:0] dy;
  vec_data_t            data_nxt;
  vec_data_t            data_r;
  logic                 valid_r;

  always_comb begin
    dx       = in_d.y >>> STAGE_IDX;
    dy       = in_d.x >>> STAGE_IDX;
    data_nxt = in_d;
    if (in_d.y > 0) begin
      data_nxt.x   = in_d.x + dx;
      data_nxt.y   = in_d.y - dy;
      data_nxt.acc = in_d.acc + ATAN_TAB[STAGE_IDX];
    end else begin
      data_nxt.x   = in_d.x - dx;
      data_nxt.y   = in_d.y + dy;
      data_nxt.acc = in_d.acc - ATAN_TAB[STAGE_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_v = valid_r;
  assign out_d = data_r;

endmodule

// ===== src/wsc_rot_stage.sv =====
// One registered micro-rotation of the rotating CORDIC that rebuilds the components.
// Depends on wsc_pkg for the item struct and the arctangent table.
module wsc_rot_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  wsc_pkg::rot_data_t in_d,
  output logic               out_v,
  output wsc_pkg::rot_data_t out_d
);
  import wsc_pkg::*;

  logic signed [RW-1:0] dx;
  logic signed [RW-1:0] dy;
  rot_data_t            data_nxt;
  rot_data_t            data_r;
  logic                 valid_r;

  always_comb begin
    dx       = in_d.y >>> STAGE_IDX;
    dy       = in_d.x >>> STAGE_IDX;
    data_nxt = in_d;
    if (in_d.z >= 0) begin
      data_nxt.x = in_d.x - dx;
      data_nxt.y = in_d.y + dy;
      data_nxt.z = in_d.z - ATAN_TAB[STAGE_IDX];
    end else begin
      data_nxt.x = in_d.x + dx;
      data_nxt.y = in_d.y - dy;
      data_nxt.z = in_d.z + ATAN_TAB[STAGE_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_v = valid_r;
  assign out_d = data_r;

endmodule

// ===== src/wsc_post.sv =====
// Final pipeline stage: rounds, negates and saturates the rotated components and
// applies the missing-speed and due-north cases. Depends on wsc_pkg.
module wsc_post #(
  parameter int COMP_WIDTH = wsc_pkg::COMP_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  wsc_pkg::rot_data_t in_d,
  output logic               out_v,
  output wsc_pkg::res_t      out_d
);
  import wsc_pkg::*;

  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [RW-1:0] HALF   = RW'(64'sd1 <<< (FRAC_SHIFT - 1));

  function automatic logic signed [RW-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic signed [RW-1:0] rnd_x;
  logic signed [RW-1:0] rnd_y;
  logic signed [RW-1:0] east_s;
  logic signed [RW-1:0] north_s;
  logic signed [RW-1:0] axis_s;
  res_t                 res_nxt;
  res_t                 res_r;
  logic                 valid_r;

  always_comb begin
    rnd_x   = (in_d.x + HALF) >>> FRAC_SHIFT;
    rnd_y   = (in_d.y + HALF) >>> FRAC_SHIFT;
    east_s  = sat(-rnd_y);
    north_s = sat(-rnd_x);
    axis_s  = sat(RW'(in_d.flags.spd));
    if (!in_d.flags.present) begin
      res_nxt = '0;
    end else if (in_d.flags.axis) begin
      res_nxt.result_valid  = 1'b1;
      res_nxt.direction_deg = DIR_MIN;
      res_nxt.derived_east  = '0;
      res_nxt.derived_north = axis_s[FIELD_W-1:0];
    end else begin
      res_nxt.result_valid  = 1'b1;
      res_nxt.direction_deg = in_d.dir;
      res_nxt.derived_east  = east_s[FIELD_W-1:0];
      res_nxt.derived_north = north_s[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_v = valid_r;
  assign out_d = res_r;

endmodule

// ===== src/wind_speed_to_components.sv =====
// Wind speed to components: direction from the model wind by a vectoring CORDIC,
// then the observed speed rotated onto that direction by a rotating CORDIC.
// Registers in order: input, vectoring stages, mid, rotating stages, post, output.
// Throughput is one item per cycle; the pipeline stalls as a whole behind a skid register.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module wind_speed_to_components #(
  parameter int COMP_WIDTH    = wsc_pkg::COMP_WIDTH_DEF,
  parameter int CORDIC_STAGES = wsc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wsc_pkg::SPD_W-1:0]           in_obs_speed,
  input  logic                                in_speed_present,
  input  logic signed [wsc_pkg::FIELD_W-1:0]  in_model_east,
  input  logic signed [wsc_pkg::FIELD_W-1:0]  in_model_north,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_result_valid,
  output logic signed [wsc_pkg::FIELD_W-1:0]  out_direction_deg,
  output logic signed [wsc_pkg::FIELD_W-1:0]  out_derived_east,
  output logic signed [wsc_pkg::FIELD_W-1:0]  out_derived_north
);
  import wsc_pkg::*;

  localparam int NST = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic en;

  logic signed [VW-1:0] east_ext;
  logic signed [VW-1:0] north_ext;
  logic signed [VW-1:0] x0;
  logic signed [VW-1:0] y0;
  vec_data_t            s0_nxt;
  vec_data_t            s0_r;
  logic                 s0_v_r;

  logic      vec_v [NST+1];
  vec_data_t vec_d [NST+1];

  logic signed [AW-1:0]  dir_full;
  logic signed [RW-1:0]  mag;
  rot_data_t             mid_nxt;
  rot_data_t             mid_r;
  logic                  mid_v_r;

  logic      rot_v [NST+1];
  rot_data_t rot_d [NST+1];

  logic post_v;
  res_t post_d;

  res_t out_d_r;
  res_t out_d_nxt;
  logic out_v_r;
  logic out_v_nxt;
  res_t skid_d_r;
  res_t skid_d_nxt;
  logic skid_v_r;
  logic skid_v_nxt;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_comb begin
    east_ext  = VW'(in_model_east);
    north_ext = VW'(in_model_north);
    x0        = -(north_ext <<< FRAC_SHIFT);
    y0        = -(east_ext <<< FRAC_SHIFT);
    s0_nxt.flags.present = in_speed_present;
    s0_nxt.flags.axis    = (in_model_east == '0) && !in_model_north[FIELD_W-1];
    s0_nxt.flags.spd     = in_obs_speed;
    s0_nxt.prod          = PROD_W'(in_obs_speed) * PROD_W'(GAIN_INV);
    if (x0 < 0) begin
      if (y0 >= 0) begin
        s0_nxt.x   = y0;
        s0_nxt.y   = -x0;
        s0_nxt.acc = ANG_90;
      end else begin
        s0_nxt.x   = -y0;
        s0_nxt.y   = x0;
        s0_nxt.acc = -ANG_90;
      end
    end else begin
      s0_nxt.x   = x0;
      s0_nxt.y   = y0;
      s0_nxt.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  assign vec_v[0] = s0_v_r;
  assign vec_d[0] = s0_r;

  for (genvar i = 0; i < NST; i++) begin : g_vec
    wsc_vec_stage #(
      .STAGE_IDX(i)
    ) u_vec (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (vec_v[i]),
      .in_d  (vec_d[i]),
      .out_v (vec_v[i+1]),
      .out_d (vec_d[i+1])
    );
  end

  always_comb begin
    dir_full      = (vec_d[NST].acc + DIR_HALF) >>> DIR_SHIFT;
    mag           = RW'(vec_d[NST].prod >> MAG_SHIFT);
    mid_nxt.flags = vec_d[NST].flags;
    if (dir_full > DIR_MAX) begin
      mid_nxt.dir = DIR_MAX;
    end else if (dir_full < DIR_MIN) begin
      mid_nxt.dir = DIR_MIN;
    end else begin
      mid_nxt.dir = dir_full[FIELD_W-1:0];
    end
    if (vec_d[NST].acc > ANG_90) begin
      mid_nxt.x = '0;
      mid_nxt.y = mag;
      mid_nxt.z = vec_d[NST].acc - ANG_90;
    end else if (vec_d[NST].acc < -ANG_90) begin
      mid_nxt.x = '0;
      mid_nxt.y = -mag;
      mid_nxt.z = vec_d[NST].acc + ANG_90;
    end else begin
      mid_nxt.x = mag;
      mid_nxt.y = '0;
      mid_nxt.z = vec_d[NST].acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (en) begin
      mid_v_r <= vec_v[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r <= mid_nxt;
    end
  end

  assign rot_v[0] = mid_v_r;
  assign rot_d[0] = mid_r;

  for (genvar i = 0; i < NST; i++) begin : g_rot
    wsc_rot_stage #(
      .STAGE_IDX(i)
    ) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (rot_v[i]),
      .in_d  (rot_d[i]),
      .out_v (rot_v[i+1]),
      .out_d (rot_d[i+1])
    );
  end

  wsc_post #(
    .COMP_WIDTH(COMP_WIDTH)
  ) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (rot_v[NST]),
    .in_d  (rot_d[NST]),
    .out_v (post_v),
    .out_d (post_d)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = post_v;
        out_d_nxt = post_d;
      end
    end else if (post_v && en) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = post_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid         = out_v_r;
  assign out_result_valid  = out_d_r.result_valid;
  assign out_direction_deg = out_d_r.direction_deg;
  assign out_derived_east  = out_d_r.derived_east;
  assign out_derived_north = out_d_r.derived_north;

  a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_valid |->
      out_direction_deg == '0 && out_derived_east == '0 && out_derived_north == '0)
    else $error("missing-speed item carries nonzero fields");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction_deg >= DIR_MIN && out_direction_deg <= DIR_MAX)
    else $error("direction outside clamp range");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ready |=> skid_v_r && $stable(skid_d_r))
    else $error("skid item lost during output stall");

endmodule
